// ===== rtl/pmc_pkg.sv =====
// Shared types for the path maximum-curvature block.
package pmc_pkg;

	typedef struct packed {
		logic busy;
		logic done;
	} pmc_status_t;

endpackage

// ===== rtl/path_max_curvature.sv =====
// Top level: path history, shared multiplier sequencer, serial divide and root, result register.
// A point that takes a turn runs 9 multiplier steps, then the divider for 2*FRAC_BITS+1 quotient bits,
// then the root unit for FRAC_BITS+1 root bits, then updates the running maximum.
// Points with no turn skip the arithmetic; the final point also loads the result register.
// One point at a time: input is ready only while the block is idle.
// Reset: arst_n clears history, point count, running maximum and the output valid.
module path_max_curvature #(
	parameter int COORD_WIDTH = 12,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// point_x, point_y, zero fill
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]           s_tdata,
	input  logic                                         s_tlast,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// peak turn sine, too_short, zero fill
	output logic [((FRAC_BITS+2+7)/8)*8-1:0]             m_tdata
);
	import pmc_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int OW    = 2*CW + 1;
	localparam int PW    = 2*OW;
	localparam int QW    = 2*FRAC_BITS + 1;
	localparam int RW    = FRAC_BITS + 1;
	localparam int OUT_W = ((FRAC_BITS + 2 + 7)/8)*8;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SQRT = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam logic [3:0] MS_CROSS1 = 4'd0;
	localparam logic [3:0] MS_CROSS2 = 4'd1;
	localparam logic [3:0] MS_UX     = 4'd2;
	localparam logic [3:0] MS_UY     = 4'd3;
	localparam logic [3:0] MS_VX     = 4'd4;
	localparam logic [3:0] MS_VY     = 4'd5;
	localparam logic [3:0] MS_ACSQ   = 4'd6;
	localparam logic [3:0] MS_LEN    = 4'd7;
	localparam logic [3:0] MS_LAUNCH = 4'd8;

	localparam logic [1:0] PTS_FULL = 2'd2;

	logic [2:0]      state_q;
	logic [3:0]      mstep_q;
	logic [CW-1:0]   older_x_q, older_y_q, prior_x_q, prior_y_q;
	logic [1:0]      pts_q;
	logic [RW-1:0]   run_max_q;
	logic            last_q;
	logic            short_q;
	logic [CW-1:0]   ux_q, uy_q, vx_q, vy_q;
	logic            sign1_q, sign2_q;
	logic [PW-1:0]   prod_q;
	logic [2*CW-1:0] p1_q;
	logic [OW-1:0]   ac_q, lu_q, lv_q;
	logic [PW-1:0]   acsq_q;
	logic            m_valid_q;
	logic [RW-1:0]   out_max_q;
	logic            out_short_q;

	logic [CW-1:0]   cx, cy;
	logic [CW:0]     dux, duy, dvx, dvy;
	logic [CW-1:0]   mux_, muy, mvx, mvy;
	logic            unz, vnz, take_turn, accept;
	logic            emit_load;
	logic [OW-1:0]   mul_a, mul_b;
	logic [2*CW+1:0] sp1, sp2, crossv;
	logic [OW-1:0]   ac_abs;
	logic            div_start, sqrt_start;
	logic [QW-1:0]   quo;
	logic [RW-1:0]   root;
	pmc_status_t     div_st, sqrt_st;

	assign cx = s_tdata[CW-1:0];
	assign cy = s_tdata[2*CW-1:CW];

	always_comb begin
		dux  = {1'b0, prior_x_q} - {1'b0, older_x_q};
		duy  = {1'b0, prior_y_q} - {1'b0, older_y_q};
		dvx  = {1'b0, cx} - {1'b0, prior_x_q};
		dvy  = {1'b0, cy} - {1'b0, prior_y_q};
		mux_ = dux[CW] ? CW'(-dux) : dux[CW-1:0];
		muy  = duy[CW] ? CW'(-duy) : duy[CW-1:0];
		mvx  = dvx[CW] ? CW'(-dvx) : dvx[CW-1:0];
		mvy  = dvy[CW] ? CW'(-dvy) : dvy[CW-1:0];
		unz  = (mux_ != '0) || (muy != '0);
		vnz  = (mvx != '0) || (mvy != '0);
		take_turn = (pts_q == PTS_FULL) && unz && vnz;
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign emit_load = (state_q == ST_EMIT) && (!m_valid_q || m_tready);

	always_comb begin
		unique case (mstep_q)
			MS_CROSS1: begin
				mul_a = OW'(ux_q);
				mul_b = OW'(vy_q);
			end
			MS_CROSS2: begin
				mul_a = OW'(uy_q);
				mul_b = OW'(vx_q);
			end
			MS_UX: begin
				mul_a = OW'(ux_q);
				mul_b = OW'(ux_q);
			end
			MS_UY: begin
				mul_a = OW'(uy_q);
				mul_b = OW'(uy_q);
			end
			MS_VX: begin
				mul_a = OW'(vx_q);
				mul_b = OW'(vx_q);
			end
			MS_VY: begin
				mul_a = OW'(vy_q);
				mul_b = OW'(vy_q);
			end
			MS_ACSQ: begin
				mul_a = ac_q;
				mul_b = ac_q;
			end
			MS_LEN: begin
				mul_a = lu_q;
				mul_b = lv_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		sp1    = sign1_q ? -{2'b00, p1_q} : {2'b00, p1_q};
		sp2    = sign2_q ? -{2'b00, prod_q[2*CW-1:0]} : {2'b00, prod_q[2*CW-1:0]};
		crossv = sp1 - sp2;
		ac_abs = crossv[2*CW+1] ? OW'(-crossv) : crossv[OW-1:0];
	end

	assign div_start  = (state_q == ST_MUL) && (mstep_q == MS_LAUNCH);
	assign sqrt_start = (state_q == ST_DIV) && div_st.done;

	pmc_div #(
		.NW(PW),
		.QW(QW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (acsq_q),
		.den   (prod_q),
		.quo   (quo),
		.st    (div_st)
	);

	pmc_sqrt #(
		.RW(RW)
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.rad   ({1'b0, quo}),
		.root  (root),
		.st    (sqrt_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mstep_q     <= MS_CROSS1;
			older_x_q   <= '0;
			older_y_q   <= '0;
			prior_x_q   <= '0;
			prior_y_q   <= '0;
			pts_q       <= '0;
			run_max_q   <= '0;
			last_q      <= 1'b0;
			short_q     <= 1'b0;
			m_valid_q   <= 1'b0;
			out_max_q   <= '0;
			out_short_q <= 1'b0;
		end else begin
			if (emit_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q  <= s_tlast;
						short_q <= (pts_q != PTS_FULL);
						mstep_q <= MS_CROSS1;
						if (s_tlast) begin
							older_x_q <= '0;
							older_y_q <= '0;
							prior_x_q <= '0;
							prior_y_q <= '0;
							pts_q     <= '0;
						end else begin
							older_x_q <= prior_x_q;
							older_y_q <= prior_y_q;
							prior_x_q <= cx;
							prior_y_q <= cy;
							if (pts_q != PTS_FULL) begin
								pts_q <= pts_q + 1'b1;
							end
						end
						if (take_turn) begin
							state_q <= ST_MUL;
						end else if (s_tlast) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MUL: begin
					if (mstep_q == MS_LAUNCH) begin
						state_q <= ST_DIV;
					end else begin
						mstep_q <= mstep_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sqrt_st.done) begin
						if (root > run_max_q) begin
							run_max_q <= root;
						end
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						out_max_q   <= run_max_q;
						out_short_q <= short_q;
						run_max_q   <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ux_q    <= mux_;
			uy_q    <= muy;
			vx_q    <= mvx;
			vy_q    <= mvy;
			sign1_q <= dux[CW] ^ dvy[CW];
			sign2_q <= duy[CW] ^ dvx[CW];
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
			case (mstep_q)
				MS_CROSS2: p1_q   <= prod_q[2*CW-1:0];
				MS_UX:     ac_q   <= ac_abs;
				MS_UY:     lu_q   <= prod_q[OW-1:0];
				MS_VX:     lu_q   <= lu_q + prod_q[OW-1:0];
				MS_VY:     lv_q   <= prod_q[OW-1:0];
				MS_ACSQ:   lv_q   <= lv_q + prod_q[OW-1:0];
				MS_LEN:    acsq_q <= prod_q;
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({out_short_q, out_max_q});

`ifndef SYNTHESIS
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_st.busy && !sqrt_st.busy)
		else $error("input ready while arithmetic units busy");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_st.done |-> root <= RW'(1) << FRAC_BITS)
		else $error("turn sine above one");

	a_max_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_max_q <= RW'(1) << FRAC_BITS)
		else $error("running maximum above one");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && out_short_q |-> out_max_q == '0)
		else $error("short path carries nonzero maximum");
`endif

endmodule

// ===== rtl/pmc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, for a quotient known to fit QW bits.
module pmc_div #(
	parameter int NW = 50,
	parameter int QW = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NW-1:0]        num,
	input  logic [NW-1:0]        den,
	output logic [QW-1:0]        quo,
	output pmc_pkg::pmc_status_t st
);
	import pmc_pkg::*;

	localparam int CNTW = $clog2(QW);

	logic [NW-1:0]   rem_q;
	logic [NW-1:0]   den_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [NW:0]     trial;
	logic [NW:0]     diff;
	logic            ge;

	always_comb begin
		trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[NW-1:0] : trial[NW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign quo     = quo_q;
	assign st.busy = busy_q;
	assign st.done = done_q;

endmodule

// ===== rtl/pmc_sqrt.sv =====
// Bit-serial integer square root, two radicand bits and one root bit per cycle.
module pmc_sqrt #(
	parameter int RW = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2*RW-1:0]      rad,
	output logic [RW-1:0]        root,
	output pmc_pkg::pmc_status_t st
);
	import pmc_pkg::*;

	localparam int CNTW = $clog2(RW);

	logic [2*RW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW+3:0]   shifted;
	logic [RW+3:0]   trial;
	logic [RW+3:0]   diff;
	logic            ge;

	always_comb begin
		shifted = {rem_q, rad_q[2*RW-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		diff    = shifted - trial;
		ge      = (shifted >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*RW-3:0], 2'b00};
			rem_q  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign root    = root_q;
	assign st.busy = busy_q;
	assign st.done = done_q;

endmodule
